>>> rtl/core/spcm_rb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcm_rb_pkg
// shared constants, types and helpers for the stereo pcm ring buffer
// ----------------------------------------------------------------------------
package spcm_rb_pkg;

  // ring geometry
  localparam int RING_DEPTH = 4096;
  localparam int IDX_W      = $clog2(RING_DEPTH);

  // pwm level format
  localparam int LEVEL_W    = 10;
  localparam int SAMPLE_W   = 16;
  localparam int FREE_OUT_W = 12;
  localparam int FREE_W     = (IDX_W > FREE_OUT_W) ? IDX_W : FREE_OUT_W;

  localparam logic [LEVEL_W-1:0] MID_LEVEL = LEVEL_W'(512);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    level_t left;
    level_t right;
  } frame_t;

  // advance a head with wrap at the ring depth
  function automatic idx_t next_idx(input idx_t i);
    idx_t n;
    n = i + idx_t'(1);
    if (i == idx_t'(RING_DEPTH - 1)) begin
      n = '0;
    end
    return n;
  endfunction

  // frames held between the heads, modulo the depth
  function automatic idx_t used_count(input idx_t wr, input idx_t rd);
    logic [IDX_W:0] sum;
    sum = {1'b0, wr} + (IDX_W + 1)'(RING_DEPTH) - {1'b0, rd};
    if (wr >= rd) begin
      sum = {1'b0, wr} - {1'b0, rd};
    end
    return sum[IDX_W-1:0];
  endfunction

  // (s >>> 6) + 512: flip the sign bit, keep the top ten bits
  function automatic level_t to_level(input logic [SAMPLE_W-1:0] s);
    return {~s[SAMPLE_W-1], s[SAMPLE_W-2:SAMPLE_W-LEVEL_W]};
  endfunction

endpackage

>>> rtl/core/stereo_pcm_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_pcm_ring_buffer
// ring of stereo pwm frames between a sample writer and a playback fetcher
// ----------------------------------------------------------------------------
// Each beat on start is either a frame write (in_action = 0) or a playback
// fetch (in_action = 1) and yields exactly one result beat, marked by
// out_strobe, in the cycle after it is taken. busy stays low, so a new beat
// can be given every cycle: the frame store has one write port and one
// registered read port, and the only read (a fetch) and the only write
// (a stored frame) of one beat never collide with those of the next. The
// receiver cannot stall, so results must be captured as they appear. No
// clearing pass is run after reset or on opening the stream: entries not
// written since the stream was opened read back as mid-scale 512 by way of a
// fill mark (the write head plus a wrapped flag). The user writes stream_open
// via cfg_wr_en / cfg_wr_data only while no beat is in flight; not enforced.
// ----------------------------------------------------------------------------
module stereo_pcm_ring_buffer
  import spcm_rb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  // command side
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_action,
  input  logic [SAMPLE_W-1:0]   in_left_sample,
  input  logic [SAMPLE_W-1:0]   in_right_sample,

  // result side
  output logic                  out_strobe,
  output logic                  out_taken,
  output logic [LEVEL_W-1:0]    out_left_level,
  output logic [LEVEL_W-1:0]    out_right_level,
  output logic [FREE_OUT_W-1:0] out_free_frames,

  // configuration
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data
);

  // how the result levels are sourced
  localparam logic [1:0] KIND_ZERO  = 2'd0;  // write beat: levels are zero
  localparam logic [1:0] KIND_FETCH = 2'd1;  // open fetch: levels from the store
  localparam logic [1:0] KIND_MID   = 2'd2;  // closed fetch: mid-scale

  localparam logic ACT_WRITE = 1'b0;

  // control state
  logic       open_r;
  idx_t       wr_idx_r, wr_idx_nxt;
  idx_t       rd_idx_r, rd_idx_nxt;
  logic       wrapped_r, wrapped_nxt;   // every entry written since opening
  logic       strobe_r;

  // result payload
  logic       taken_r, taken_nxt;
  logic [1:0] kind_r, kind_nxt;
  idx_t       free_r, free_nxt;
  logic       hit_r;                    // fetched entry holds written data
  frame_t     rd_data_r;

  // frame store
  frame_t     mem [RING_DEPTH];
  logic       mem_we;
  frame_t     mem_wdata;
  logic       mem_re;

  logic       accept;
  logic       is_fetch;
  idx_t       used_now;
  logic       ring_full;

  // never stalls the sender: one beat per cycle
  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_fetch = (in_action != ACT_WRITE);

  assign used_now  = used_count(wr_idx_r, rd_idx_r);
  assign ring_full = (used_now == idx_t'(RING_DEPTH - 1));

  assign mem_wdata = '{left: to_level(in_left_sample), right: to_level(in_right_sample)};

  // beat decode
  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    wrapped_nxt = wrapped_r;
    taken_nxt   = 1'b0;
    kind_nxt    = KIND_ZERO;
    free_nxt    = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    if (accept) begin
      if (!open_r) begin
        // closed: writes look taken but are dropped, fetches play silence
        taken_nxt = !is_fetch;
        kind_nxt  = is_fetch ? KIND_MID : KIND_ZERO;
      end else if (is_fetch) begin
        // looping playback: no underrun check
        mem_re     = 1'b1;
        kind_nxt   = KIND_FETCH;
        rd_idx_nxt = next_idx(rd_idx_r);
        free_nxt   = idx_t'(RING_DEPTH - 1) - used_count(wr_idx_r, rd_idx_nxt);
      end else begin
        if (!ring_full) begin
          mem_we     = 1'b1;
          taken_nxt  = 1'b1;
          wr_idx_nxt = next_idx(wr_idx_r);
          if (wr_idx_r == idx_t'(RING_DEPTH - 1)) begin
            wrapped_nxt = 1'b1;
          end
        end
        free_nxt = idx_t'(RING_DEPTH - 1) - used_count(wr_idx_nxt, rd_idx_r);
      end
    end
  end

  // heads, stream flag and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      wrapped_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (cfg_wr_en) begin
        open_r <= cfg_wr_data;
        // opening restarts the ring at mid-scale via the fill mark
        if (cfg_wr_data && !open_r) begin
          wr_idx_r  <= '0;
          rd_idx_r  <= '0;
          wrapped_r <= 1'b0;
        end
      end else begin
        wr_idx_r  <= wr_idx_nxt;
        rd_idx_r  <= rd_idx_nxt;
        wrapped_r <= wrapped_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      taken_r <= taken_nxt;
      kind_r  <= kind_nxt;
      free_r  <= free_nxt;
      hit_r   <= wrapped_r || (rd_idx_r < wr_idx_r);
    end
  end

  // frame store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r] <= mem_wdata;
    end
  end

  // frame store read port, registered
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // result beat
  assign out_strobe      = strobe_r;
  assign out_taken       = taken_r;
  assign out_free_frames = FREE_OUT_W'(free_r);

  always_comb begin
    case (kind_r)
      KIND_FETCH: begin
        out_left_level  = hit_r ? rd_data_r.left  : MID_LEVEL;
        out_right_level = hit_r ? rd_data_r.right : MID_LEVEL;
      end
      KIND_MID: begin
        out_left_level  = MID_LEVEL;
        out_right_level = MID_LEVEL;
      end
      default: begin
        out_left_level  = '0;
        out_right_level = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/spcm_rb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcm_rb_checker
// port-level checks on the ring buffer, bound to the top level
// ----------------------------------------------------------------------------
module spcm_rb_checker
  import spcm_rb_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_action,
  input logic                  out_strobe,
  input logic                  out_taken,
  input logic [LEVEL_W-1:0]    out_left_level,
  input logic [LEVEL_W-1:0]    out_right_level
);

  // every taken beat gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe)
    else $error("no result after accepted beat");

  // no result without a beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_strobe)
    else $error("result without beat");

  // a fetch never reports taken
  a_fetch_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action) |=> !out_taken)
    else $error("fetch reported taken");

  // write beats carry zero levels
  a_write_zero_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_action) |=>
      (out_left_level == '0 && out_right_level == '0))
    else $error("write beat with non-zero level");

  // reset quiets the result side
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

endmodule

bind stereo_pcm_ring_buffer spcm_rb_checker u_spcm_rb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_action       (in_action),
  .out_strobe      (out_strobe),
  .out_taken       (out_taken),
  .out_left_level  (out_left_level),
  .out_right_level (out_right_level)
);
